FILE: hdl/pcd_pkg.sv
package pcd_pkg;

  typedef enum logic [2:0] {
    SEC_SIG  = 3'd0,
    SEC_LEN  = 3'd1,
    SEC_TYPE = 3'd2,
    SEC_DATA = 3'd3,
    SEC_CRC  = 3'd4,
    SEC_IGN  = 3'd5
  } section_t;

  localparam logic [31:0] SIG_BYTES     = 32'd8;
  localparam logic [31:0] FIELD_BYTES   = 32'd4;
  localparam logic [31:0] TYPE_IEND     = 32'h49454E44;
  localparam logic [7:0]  MAX_CHUNKS_RST = 8'd10;
  localparam logic [7:0]  COUNT_SAT     = 8'd255;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic [2:0]  section;
    logic [7:0]  chunk_number;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic [31:0] chunk_crc;
    logic        chunk_done;
    logic        stream_end;
  } result_t;

endpackage

FILE: hdl/pcd_in_stage.sv
module pcd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] file_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // free when empty or when the held word moves on this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= file_byte;
    end
  end

endmodule

FILE: hdl/pcd_core.sv
module pcd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  take,
  input  logic [7:0]            byte_in,
  output pcd_pkg::result_t      res
);

  logic [7:0]        max_chunks;
  pcd_pkg::section_t current_section, current_section_next;
  logic [31:0]       byte_position, byte_position_next;
  logic [31:0]       length_reg, length_reg_next;
  logic [31:0]       type_reg, type_reg_next;
  logic [31:0]       crc_reg, crc_reg_next;
  logic [7:0]        chunks_completed, chunks_completed_next;
  logic [31:0]       pos_inc;
  logic [2:0]        sec_out;
  logic              done;
  logic              fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunks <= pcd_pkg::MAX_CHUNKS_RST;
    end else if (cfg_we) begin
      max_chunks <= cfg_wdata;
    end
  end

  assign pos_inc = byte_position + 32'd1;

  always_comb begin
    current_section_next  = current_section;
    byte_position_next    = byte_position;
    length_reg_next       = length_reg;
    type_reg_next         = type_reg;
    crc_reg_next          = crc_reg;
    chunks_completed_next = chunks_completed;
    sec_out               = current_section;
    done                  = 1'b0;
    fin                   = 1'b0;
    unique case (current_section)
      pcd_pkg::SEC_SIG: begin
        byte_position_next = pos_inc;
        if (pos_inc >= pcd_pkg::SIG_BYTES) begin
          current_section_next = pcd_pkg::SEC_LEN;
          byte_position_next   = '0;
        end
      end
      pcd_pkg::SEC_LEN: begin
        if (byte_position == '0) begin
          length_reg_next = {24'd0, byte_in};
          type_reg_next   = '0;
          crc_reg_next    = '0;
        end else begin
          length_reg_next = {length_reg[23:0], byte_in};
        end
        byte_position_next = pos_inc;
        if (pos_inc >= pcd_pkg::FIELD_BYTES) begin
          current_section_next = pcd_pkg::SEC_TYPE;
          byte_position_next   = '0;
        end
      end
      pcd_pkg::SEC_TYPE: begin
        type_reg_next      = {type_reg[23:0], byte_in};
        byte_position_next = pos_inc;
        if (pos_inc >= pcd_pkg::FIELD_BYTES) begin
          byte_position_next   = '0;
          current_section_next = (length_reg != '0) ? pcd_pkg::SEC_DATA : pcd_pkg::SEC_CRC;
        end
      end
      pcd_pkg::SEC_DATA: begin
        byte_position_next = pos_inc;
        if (pos_inc >= length_reg) begin
          current_section_next = pcd_pkg::SEC_CRC;
          byte_position_next   = '0;
        end
      end
      pcd_pkg::SEC_CRC: begin
        crc_reg_next       = {crc_reg[23:0], byte_in};
        byte_position_next = pos_inc;
        if (pos_inc >= pcd_pkg::FIELD_BYTES) begin
          byte_position_next = '0;
          done               = 1'b1;
          if (chunks_completed < pcd_pkg::COUNT_SAT) begin
            chunks_completed_next = chunks_completed + 8'd1;
          end
          fin = (type_reg == pcd_pkg::TYPE_IEND) || (chunks_completed_next >= max_chunks);
          current_section_next = fin ? pcd_pkg::SEC_IGN : pcd_pkg::SEC_LEN;
        end
      end
      default: begin
        sec_out = pcd_pkg::SEC_IGN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_section  <= pcd_pkg::SEC_SIG;
      byte_position    <= '0;
      length_reg       <= '0;
      type_reg         <= '0;
      crc_reg          <= '0;
      chunks_completed <= '0;
    end else if (take) begin
      current_section  <= current_section_next;
      byte_position    <= byte_position_next;
      length_reg       <= length_reg_next;
      type_reg         <= type_reg_next;
      crc_reg          <= crc_reg_next;
      chunks_completed <= chunks_completed_next;
    end
  end

  always_comb begin
    res.echo_byte    = byte_in;
    res.section      = sec_out;
    res.chunk_number = chunks_completed;
    res.chunk_length = length_reg_next;
    res.chunk_type   = type_reg_next;
    res.chunk_crc    = crc_reg_next;
    res.chunk_done   = done;
    res.stream_end   = fin;
  end

`ifndef SYNTH
  a_end_goes_ignored: assert property (@(posedge clk) disable iff (rst)
    take && res.stream_end |=> current_section == pcd_pkg::SEC_IGN)
    else $error("stream end did not move to ignored section");

  a_done_next_chunk: assert property (@(posedge clk) disable iff (rst)
    take && res.chunk_done && !res.stream_end |=> current_section == pcd_pkg::SEC_LEN &&
      byte_position == '0)
    else $error("completed chunk did not restart at length");

  a_ignored_sticks: assert property (@(posedge clk) disable iff (rst)
    current_section == pcd_pkg::SEC_IGN |=> current_section == pcd_pkg::SEC_IGN &&
      $stable(chunks_completed))
    else $error("left ignored section after stream end");

  a_end_needs_done: assert property (@(posedge clk) disable iff (rst)
    res.stream_end |-> res.chunk_done && current_section == pcd_pkg::SEC_CRC)
    else $error("stream end without chunk completion");
`endif

endmodule

FILE: hdl/pcd_out_stage.sv
module pcd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  pcd_pkg::result_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output pcd_pkg::result_t res_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

FILE: hdl/png_chunk_deframer_unit.sv
// a byte word moves from the input register into the result register by one counter
// compare and one shift; throughput: one word per cycle unless out_ready stalls, set
// by the single input register and result register pair
// reset: rst is synchronous, active high; parser returns to the signature section,
// all chunk registers and the chunk count clear, max_chunks returns to 10
module png_chunk_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_chunks, written whenever cfg_we is high
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // byte words in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  file_byte,
  // tagged words out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  echo_byte,
  output logic [2:0]  section,
  output logic [7:0]  chunk_number,
  output logic [31:0] chunk_length,
  output logic [31:0] chunk_type,
  output logic [31:0] chunk_crc,
  output logic        chunk_done,
  output logic        stream_end
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             take;
  pcd_pkg::result_t res;
  pcd_pkg::result_t res_q;

  // the held word is parsed when the result register is empty or being drained
  assign take = held_valid && (!out_valid || out_ready);

  // input register, decoupled from the parser by the take strobe
  pcd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .file_byte  (file_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // section tracking, field assembly and end detection
  pcd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .byte_in   (held_byte),
    .res       (res)
  );

  // result register
  pcd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign echo_byte    = res_q.echo_byte;
  assign section      = res_q.section;
  assign chunk_number = res_q.chunk_number;
  assign chunk_length = res_q.chunk_length;
  assign chunk_type   = res_q.chunk_type;
  assign chunk_crc    = res_q.chunk_crc;
  assign chunk_done   = res_q.chunk_done;
  assign stream_end   = res_q.stream_end;

endmodule
